// ----- rtl/gcr62_pkg.sv -----
// ----------------------------------------------------------------------------
// gcr62_pkg
// Shared types, constants and the 6-and-2 GCR code tables.
// ----------------------------------------------------------------------------
package gcr62_pkg;

    localparam int unsigned AUX_DEPTH   = 86;
    localparam int unsigned AUX_AW      = 7;
    localparam int unsigned POS_W       = 9;
    localparam int unsigned GRP_W       = 2;
    localparam int unsigned VAL_W       = 6;

    localparam logic [POS_W-1:0] POS_AUX_END = POS_W'(AUX_DEPTH);
    localparam logic [POS_W-1:0] POS_LAST    = 9'h156;
    localparam logic [AUX_AW-1:0] AUX_LAST   = AUX_AW'(AUX_DEPTH - 1);

    localparam logic RK_DATA   = 1'b0;
    localparam logic RK_STATUS = 1'b1;

    localparam logic [7:0] GCR_ENC [64] = '{
        8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
        8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
        8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
        8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
        8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
        8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
        8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
        8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
    };

    // invalid codes decode to zero; bit 7 of a nibble is always set on disk
    function automatic logic [VAL_W-1:0] gcr_decode(input logic [6:0] code);
        logic [VAL_W-1:0] val;
        val = '0;
        for (int i = 0; i < 64; i++) begin
            if (GCR_ENC[i][6:0] == code) begin
                val = VAL_W'(i);
            end
        end
        return val;
    endfunction

    typedef struct packed {
        logic              kind;
        logic [VAL_W-1:0]  chain;
        logic [7:0]        byte_pos;
        logic [GRP_W-1:0]  group;
        logic              bad;
    } t_beat_info;

endpackage

// ----- rtl/gcr62_ram.sv -----
// ----------------------------------------------------------------------------
// gcr62_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module gcr62_ram #(
    parameter int unsigned WIDTH = 6,
    parameter int unsigned DEPTH = 86
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/gcr62_front.sv -----
// ----------------------------------------------------------------------------
// gcr62_front
// Nibble intake: GCR translate, XOR chain, sector position, aux store
// access and the first pipeline register.
// ----------------------------------------------------------------------------
module gcr62_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [7:0]              s_axis_tdata,   // [7:0] disk_nibble
    input  logic                    i_take,
    output logic                    o_valid,
    output gcr62_pkg::t_beat_info   o_info,
    output logic [gcr62_pkg::VAL_W-1:0] o_aux
);
    import gcr62_pkg::*;

    logic               r_valid;
    t_beat_info         r_info;
    logic [VAL_W-1:0]   r_chain;
    logic [POS_W-1:0]   r_pos;
    logic [AUX_AW-1:0]  r_aux_idx;
    logic [GRP_W-1:0]   r_group;

    logic               accept;
    logic               free;
    logic               is_status;
    logic               is_aux;
    logic [VAL_W-1:0]   chain_calc;
    logic [POS_W-1:0]   byte_pos;
    t_beat_info         n_info;

    assign free          = !r_valid || i_take;
    assign s_axis_tready = free;
    assign accept        = s_axis_tvalid && free;
    assign is_status     = (r_pos >= POS_LAST);
    assign is_aux        = (r_pos < POS_AUX_END);
    assign chain_calc    = gcr_decode(s_axis_tdata[6:0]) ^ r_chain;
    assign byte_pos      = r_pos - POS_AUX_END;

    always_comb begin
        n_info.kind     = is_status ? RK_STATUS : RK_DATA;
        n_info.chain    = chain_calc;
        n_info.byte_pos = byte_pos[7:0];
        n_info.group    = r_group;
        n_info.bad      = is_status && (s_axis_tdata != GCR_ENC[r_chain]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_chain   <= '0;
            r_pos     <= '0;
            r_aux_idx <= '0;
            r_group   <= '0;
        end else begin
            if (free) begin
                r_valid <= accept && !is_aux;
            end
            if (accept) begin
                if (is_status) begin
                    r_chain   <= '0;
                    r_pos     <= '0;
                    r_aux_idx <= '0;
                    r_group   <= '0;
                end else begin
                    r_chain <= chain_calc;
                    r_pos   <= r_pos + 1'b1;
                    if (!is_aux) begin
                        if (r_aux_idx == AUX_LAST) begin
                            r_aux_idx <= '0;
                            r_group   <= r_group + 1'b1;
                        end else begin
                            r_aux_idx <= r_aux_idx + 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_info <= n_info;
        end
    end

    gcr62_ram #(
        .WIDTH (VAL_W),
        .DEPTH (AUX_DEPTH)
    ) u_aux (
        .i_clk   (i_clk),
        .i_we    (accept && is_aux),
        .i_waddr (r_pos[AUX_AW-1:0]),
        .i_wdata (chain_calc),
        .i_re    (accept && !is_aux && !is_status),
        .i_raddr (r_aux_idx),
        .o_rdata (o_aux)
    );

    assign o_valid = r_valid;
    assign o_info  = r_info;
endmodule

// ----- rtl/gcr62_back.sv -----
// ----------------------------------------------------------------------------
// gcr62_back
// Byte assembly from chain value and aux bit pair, output register.
// ----------------------------------------------------------------------------
module gcr62_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  gcr62_pkg::t_beat_info       i_info,
    input  logic [gcr62_pkg::VAL_W-1:0] i_aux,
    output logic                        o_take,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [23:0]                 m_axis_tdata,  // [7:0] data_byte,
                                                       // [15:8] byte_position,
                                                       // [16] checksum_bad
    output logic                        m_axis_tuser   // [0] result_kind
);
    import gcr62_pkg::*;

    logic        r_valid;
    logic [16:0] r_data;
    logic        r_kind;
    logic        load;
    logic [1:0]  pair;
    logic [16:0] n_data;

    assign load   = !r_valid || m_axis_tready;
    assign o_take = i_valid && load;

    always_comb begin
        case (i_info.group)
            2'd0:    pair = {i_aux[0], i_aux[1]};
            2'd1:    pair = {i_aux[2], i_aux[3]};
            2'd2:    pair = {i_aux[4], i_aux[5]};
            default: pair = 2'b00;
        endcase
        if (i_info.kind == RK_STATUS) begin
            n_data = {i_info.bad, 8'h00, 8'h00};
        end else begin
            n_data = {1'b0, i_info.byte_pos, i_info.chain, pair};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_data <= n_data;
            r_kind <= i_info.kind;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {7'b0, r_data};
    assign m_axis_tuser  = r_kind;
endmodule

// ----- rtl/gcr_six_and_two_sector_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// gcr_six_and_two_sector_decoder_unit
// 6-and-2 GCR sector decoder: 343 nibbles in, 256 data beats and one
// checksum status beat out.
// Pipeline: front register (with the aux RAM read) and output register.
// Throughput: one nibble per cycle while the output is not stalled by m_axis_tready.
// Reset: synchronous, active low; clears chain value and sector position.
// The aux RAM has no reset; each entry is written before it is read.
// ----------------------------------------------------------------------------
module gcr_six_and_two_sector_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] disk_nibble
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [15:8] byte_position,
                                        // [16] checksum_bad
    output logic        m_axis_tuser    // [0] result_kind
);
    import gcr62_pkg::*;

    logic               s1_valid;
    logic               s1_take;
    t_beat_info         s1_info;
    logic [VAL_W-1:0]   s1_aux;

    gcr62_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_take        (s1_take),
        .o_valid       (s1_valid),
        .o_info        (s1_info),
        .o_aux         (s1_aux)
    );

    gcr62_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s1_valid),
        .i_info        (s1_info),
        .i_aux         (s1_aux),
        .o_take        (s1_take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );
endmodule
